// ===== src/odhm_pkg.sv =====
// ----------------------------------------------------------------------------
// odhm_pkg
// shared widths, codes, sine table and rounding constants of the omni drive
// heading mixer
// ----------------------------------------------------------------------------
package odhm_pkg;

   localparam int ANGLE_W         = 12;
   localparam int POWER_W         = 8;
   localparam int DUTY_W          = 8;
   localparam int BRIDGE_W        = 2;
   localparam int MASK_W          = 4;
   localparam int MOTORS          = 4;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 8;
   localparam int ANGLE_STEPS_DEF = 3600;

   localparam int TENTHS_TURN = 3600;
   localparam int QUARTER     = 900;
   localparam int HALF        = 1800;
   localparam int THREE_QTR   = 2700;
   localparam int PERCENT     = 100;
   localparam int DUTY_MAX    = 255;

   localparam int SINE_W    = 15;
   localparam int R_W       = 10;
   localparam int IDX_W     = 5;
   localparam int FRAC_W    = 6;
   localparam int STEP_W    = 12;
   localparam int SINE_LAST = 18;

   // point spacing of the sine table and reciprocals for the small divides
   localparam int STEP_TENTHS  = 50;
   localparam int IDX_RECIP    = 1311;
   localparam int IDX_SHIFT    = 16;
   localparam int INTERP_RECIP = 335545;
   localparam int INTERP_SHIFT = 24;
   localparam int PCT_RECIP    = 167773;
   localparam int PCT_SHIFT    = 24;

   // heading correction gain, 78.43 per half turn scaled by 200
   localparam int CORR_GAIN = 15686;
   localparam int CORR_W    = 14;

   localparam logic [BRIDGE_W-1:0] BRIDGE_OFF  = 2'd0;
   localparam logic [BRIDGE_W-1:0] BRIDGE_PIN2 = 2'd1;
   localparam logic [BRIDGE_W-1:0] BRIDGE_PIN1 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_A  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_B  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_C  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_D  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT = 3'd4;

   typedef struct packed {
      logic           neg;
      logic [R_W-1:0] r;
   } fold_type;

   // q0.15 sine every five degrees over a quarter wave
   function automatic logic [SINE_W-1:0] sine_point(input logic [IDX_W-1:0] idx);
      logic [SINE_W-1:0] v;
      case (idx)
         5'd0:    v = 15'd0;
         5'd1:    v = 15'd2856;
         5'd2:    v = 15'd5690;
         5'd3:    v = 15'd8481;
         5'd4:    v = 15'd11207;
         5'd5:    v = 15'd13848;
         5'd6:    v = 15'd16384;
         5'd7:    v = 15'd18795;
         5'd8:    v = 15'd21063;
         5'd9:    v = 15'd23170;
         5'd10:   v = 15'd25102;
         5'd11:   v = 15'd26842;
         5'd12:   v = 15'd28378;
         5'd13:   v = 15'd29698;
         5'd14:   v = 15'd30792;
         5'd15:   v = 15'd31652;
         5'd16:   v = 15'd32270;
         5'd17:   v = 15'd32643;
         default: v = 15'd32767;
      endcase
      return v;
   endfunction

   function automatic logic [STEP_W-1:0] sine_step(input logic [IDX_W-1:0] idx);
      logic [SINE_W-1:0] d;
      if (idx >= IDX_W'(SINE_LAST)) begin
         d = '0;
      end else begin
         d = sine_point(idx + 5'd1) - sine_point(idx);
      end
      return d[STEP_W-1:0];
   endfunction

   // quarter wave fold of an angle in tenths, t below a full turn
   function automatic fold_type fold_angle(input logic [ANGLE_W-1:0] t);
      fold_type f;
      if (t < ANGLE_W'(QUARTER)) begin
         f.neg = 1'b0;
         f.r   = R_W'(t);
      end else if (t < ANGLE_W'(HALF)) begin
         f.neg = 1'b0;
         f.r   = R_W'(ANGLE_W'(HALF) - t);
      end else if (t < ANGLE_W'(THREE_QTR)) begin
         f.neg = 1'b1;
         f.r   = R_W'(t - ANGLE_W'(HALF));
      end else begin
         f.neg = 1'b1;
         f.r   = R_W'(ANGLE_W'(TENTHS_TURN) - t);
      end
      return f;
   endfunction

   // speed plus or minus the correction, truncated toward zero as one sum
   function automatic logic signed [9:0] apply_corr(input logic signed [7:0] speed,
                                                   input logic              pos,
                                                   input logic [7:0]        g,
                                                   input logic              frac);
      logic signed [9:0] s;
      logic signed [9:0] gs;
      gs = $signed({2'b00, g});
      if (pos) begin
         s = 10'(speed) + gs;
         if (s < 0 && frac) begin
            s = s + 10'sd1;
         end
      end else begin
         s = 10'(speed) - gs;
         if (s > 0 && frac) begin
            s = s - 10'sd1;
         end
      end
      return s;
   endfunction

endpackage

// ===== src/omni_drive_heading_mixer_top.sv =====
// ----------------------------------------------------------------------------
// omni_drive_heading_mixer_top
// four wheel omni drive mixer with heading hold: angle wrap, sine and cosine
// interpolation, heading correction and per motor duty and bridge code
// ----------------------------------------------------------------------------
// throughput: one word per cycle unless rsp_stall holds the pipeline; the chain of
//    reciprocal multiplies for the angle wraps, the sine lookup and the percent
//    scaling sets the 11 stages
// rsp_stall freezes the whole pipeline while rsp_valid is high, nothing is dropped or repeated
// reset clears all valid bits and loads the register reset values
module omni_drive_heading_mixer_top
   import odhm_pkg::*;
#(
   parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ANGLE_W-1:0]         req_movement_angle,
   input  logic signed [POWER_W-1:0]  req_drive_power,
   input  logic [ANGLE_W-1:0]         req_heading,
   input  logic [ANGLE_W-1:0]         req_locked_angle,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DUTY_W-1:0]          rsp_duty_a,
   output logic [DUTY_W-1:0]          rsp_duty_b,
   output logic [DUTY_W-1:0]          rsp_duty_c,
   output logic [DUTY_W-1:0]          rsp_duty_d,
   output logic [BRIDGE_W-1:0]        rsp_bridge_a,
   output logic [BRIDGE_W-1:0]        rsp_bridge_b,
   output logic [BRIDGE_W-1:0]        rsp_bridge_c,
   output logic [BRIDGE_W-1:0]        rsp_bridge_d,
   input  logic                       csr_wen,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int NS    = 11;
   localparam int S_W   = $clog2(ANGLE_STEPS + 1);
   localparam int KE    = (2**ANGLE_W - 1 + ANGLE_STEPS - 1) / ANGLE_STEPS;
   localparam int U_MAX = 2**ANGLE_W + (KE + 1) * ANGLE_STEPS + ANGLE_STEPS / 8;
   localparam int U_W   = $clog2(U_MAX + 1);
   localparam int Q_W   = $clog2(U_MAX / ANGLE_STEPS + 1);
   localparam int SHM   = U_W + S_W + 2;
   localparam longint RM = (longint'(1) << SHM) / ANGLE_STEPS + 1;
   localparam int PM_W  = SHM + Q_W;
   localparam int SHT   = 2 * S_W + 1;
   localparam longint RT = (longint'(TENTHS_TURN) << SHT) / ANGLE_STEPS + 1;
   localparam int PT_W  = SHT + ANGLE_W;
   localparam int K_W   = S_W + CORR_W;
   localparam longint DEN = longint'(ANGLE_STEPS) * PERCENT;
   localparam int D_W   = $clog2(DEN + 1);
   localparam int G_W   = 8;
   localparam int SHD   = K_W + D_W + 1;
   localparam longint RD = (longint'(1) << SHD) / DEN + 1;
   localparam int PD_W  = SHD + G_W;
   localparam int M8_W  = ANGLE_W + 3;
   localparam int PI_W  = IDX_SHIFT + IDX_W;
   localparam int PR_W  = STEP_W + FRAC_W;
   localparam int PN_W  = INTERP_SHIFT + STEP_W;
   localparam int PS_W  = SINE_W + POWER_W;
   localparam int VM_W  = 9;
   localparam int PW_W  = VM_W + DUTY_W;
   localparam int MG_W  = 10;
   localparam int PP_W  = PCT_SHIFT + MG_W;

   typedef struct packed {
      logic               straight;
      logic               pneg;
      logic [POWER_W-1:0] pmag;
   } side_type;

   // configuration
   logic [DUTY_W-1:0] maxp_ff [MOTORS];
   logic [MASK_W-1:0] inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTORS; i++) begin
            maxp_ff[i] <= DUTY_W'(DUTY_MAX);
         end
         inv_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_MAX_A:  maxp_ff[0] <= csr_wdata;
            CSR_MAX_B:  maxp_ff[1] <= csr_wdata;
            CSR_MAX_C:  maxp_ff[2] <= csr_wdata;
            CSR_MAX_D:  maxp_ff[3] <= csr_wdata;
            CSR_INVERT: inv_ff     <= csr_wdata[MASK_W-1:0];
            default:    ;
         endcase
      end
   end

   // pipeline control
   logic          adv;
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;

   assign adv       = !(vld_ff[NS-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NS-1];
   assign vld_in    = {vld_ff[NS-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage registers
   logic [U_W-1:0]          ue1_ff, ue1_in, uw1_ff, uw1_in;
   side_type                sd1_ff, sd1_in;
   logic [Q_W-1:0]          qe2_ff, qe2_in, qw2_ff, qw2_in;
   logic [U_W-1:0]          ue2_ff, uw2_ff;
   side_type                sd2_ff;
   logic [S_W-1:0]          e3_ff, e3_in, w3_ff, w3_in;
   side_type                sd3_ff;
   logic [ANGLE_W-1:0]      t4_ff, t4_in;
   logic [K_W-1:0]          k4_ff, k4_in;
   logic                    pos4_ff, pos4_in;
   side_type                sd4_ff;
   fold_type                fs5_ff, fs5_in, fc5_ff, fc5_in;
   logic [IDX_W-1:0]        is5_ff, is5_in, ic5_ff, ic5_in;
   logic [G_W-1:0]          g5_ff, g5_in;
   logic [K_W-1:0]          k5_ff;
   logic                    pos5_ff;
   side_type                sd5_ff;
   logic [SINE_W-1:0]       bs6_ff, bs6_in, bc6_ff, bc6_in;
   logic [PR_W-1:0]         ps6_ff, ps6_in, pc6_ff, pc6_in;
   logic                    ns6_ff, nc6_ff;
   logic [G_W-1:0]          g6_ff;
   logic                    nz6_ff, nz6_in;
   logic                    pos6_ff;
   side_type                sd6_ff;
   logic [SINE_W-1:0]       vs7_ff, vs7_in, vc7_ff, vc7_in;
   logic                    ns7_ff, nc7_ff;
   logic [G_W-1:0]          g7_ff;
   logic                    nz7_ff, pos7_ff;
   side_type                sd7_ff;
   logic signed [7:0]       ad8_ff, ad8_in, bc8_ff, bc8_in;
   logic [G_W-1:0]          g8_ff;
   logic                    nz8_ff, pos8_ff, str8_ff;
   logic signed [9:0]       v9_ff [MOTORS];
   logic signed [9:0]       v9_in [MOTORS];
   logic [PW_W-1:0]         p10_ff [MOTORS];
   logic [PW_W-1:0]         p10_in [MOTORS];
   logic                    n10_ff [MOTORS];
   logic                    n10_in [MOTORS];
   logic [DUTY_W-1:0]       duty11_ff [MOTORS];
   logic [DUTY_W-1:0]       duty11_in [MOTORS];
   logic [BRIDGE_W-1:0]     br11_ff [MOTORS];
   logic [BRIDGE_W-1:0]     br11_in [MOTORS];

   // combinational temporaries
   logic [M8_W-1:0]         m8;
   logic [PM_W-1:0]         pme, pmw;
   logic [PT_W-1:0]         ptw;
   logic [S_W:0]            e2x;
   logic                    sub_e;
   logic [S_W-1:0]          xsel;
   logic [ANGLE_W-1:0]      tc;
   logic [PI_W-1:0]         pis, pic;
   logic [PD_W-1:0]         pdg;
   logic [FRAC_W-1:0]       fs, fc;
   logic [PN_W-1:0]         pns, pnc;
   logic [PS_W-1:0]         pss, psc;
   logic [7:0]              mags, magc;
   logic [VM_W-1:0]         vmag [MOTORS];
   logic [PP_W-1:0]         ppct [MOTORS];
   logic [MG_W-1:0]         mg [MOTORS];

   always_comb begin
      // stage 1: offset the angle differences so they stay positive, power sign and magnitude, straight flag
      ue1_in = U_W'(req_heading) + U_W'(KE * ANGLE_STEPS) - U_W'(req_locked_angle);
      uw1_in = U_W'(ANGLE_STEPS + ANGLE_STEPS / 8 + KE * ANGLE_STEPS)
             - U_W'(req_movement_angle);
      m8 = {req_movement_angle, 3'b000};
      sd1_in.straight = (m8 <= M8_W'(ANGLE_STEPS)) || (m8 >= M8_W'(7 * ANGLE_STEPS))
                      || ((m8 >= M8_W'(3 * ANGLE_STEPS)) && (m8 <= M8_W'(5 * ANGLE_STEPS)));
      sd1_in.pneg = req_drive_power[POWER_W-1];
      sd1_in.pmag = sd1_in.pneg ? POWER_W'(-req_drive_power) : POWER_W'(req_drive_power);

      // stage 2: quotients by the turn length
      pme = PM_W'(ue1_ff) * PM_W'(RM);
      pmw = PM_W'(uw1_ff) * PM_W'(RM);
      qe2_in = pme[PM_W-1:SHM];
      qw2_in = pmw[PM_W-1:SHM];

      // stage 3: wrapped heading error and rotated travel angle
      e3_in = S_W'(ue2_ff - U_W'(qe2_ff) * U_W'(ANGLE_STEPS));
      w3_in = S_W'(uw2_ff - U_W'(qw2_ff) * U_W'(ANGLE_STEPS));

      // stage 4: angle in tenths, correction numerator
      ptw   = PT_W'(w3_ff) * PT_W'(RT);
      t4_in = ptw[SHT +: ANGLE_W];
      e2x   = {e3_ff, 1'b0};
      if (sd3_ff.straight) begin
         sub_e   = e2x > (S_W + 1)'(ANGLE_STEPS);
         pos4_in = sub_e;
      end else begin
         sub_e   = e2x >= (S_W + 1)'(ANGLE_STEPS);
         pos4_in = !sub_e;
      end
      xsel  = sub_e ? S_W'(ANGLE_STEPS) - e3_ff : e3_ff;
      k4_in = K_W'(xsel) * K_W'(CORR_GAIN);

      // stage 5: quarter wave fold, table index, correction quotient
      tc = (t4_ff >= ANGLE_W'(TENTHS_TURN - QUARTER))
         ? t4_ff - ANGLE_W'(TENTHS_TURN - QUARTER) : t4_ff + ANGLE_W'(QUARTER);
      fs5_in = fold_angle(t4_ff);
      fc5_in = fold_angle(tc);
      pis    = PI_W'(fs5_in.r) * PI_W'(IDX_RECIP);
      pic    = PI_W'(fc5_in.r) * PI_W'(IDX_RECIP);
      is5_in = pis[IDX_SHIFT +: IDX_W];
      ic5_in = pic[IDX_SHIFT +: IDX_W];
      pdg    = PD_W'(k4_ff) * PD_W'(RD);
      g5_in  = pdg[SHD +: G_W];

      // stage 6: table point and interpolation product, remainder test
      fs     = FRAC_W'(fs5_ff.r - R_W'(is5_ff) * R_W'(STEP_TENTHS));
      fc     = FRAC_W'(fc5_ff.r - R_W'(ic5_ff) * R_W'(STEP_TENTHS));
      bs6_in = sine_point(is5_ff);
      bc6_in = sine_point(ic5_ff);
      ps6_in = PR_W'(sine_step(is5_ff)) * PR_W'(fs);
      pc6_in = PR_W'(sine_step(ic5_ff)) * PR_W'(fc);
      nz6_in = (K_W'(g5_ff) * K_W'(DEN)) != k5_ff;

      // stage 7: interpolated sine and cosine magnitudes
      pns    = PN_W'(ps6_ff) * PN_W'(INTERP_RECIP);
      pnc    = PN_W'(pc6_ff) * PN_W'(INTERP_RECIP);
      vs7_in = bs6_ff + SINE_W'(pns[INTERP_SHIFT +: STEP_W]);
      vc7_in = bc6_ff + SINE_W'(pnc[INTERP_SHIFT +: STEP_W]);

      // stage 8: pair speeds, truncated toward zero
      pss    = PS_W'(vs7_ff) * PS_W'(sd7_ff.pmag);
      psc    = PS_W'(vc7_ff) * PS_W'(sd7_ff.pmag);
      mags   = pss[SINE_W +: 8];
      magc   = psc[SINE_W +: 8];
      ad8_in = (ns7_ff ^ sd7_ff.pneg) ? -$signed(mags) : $signed(mags);
      bc8_in = (nc7_ff ^ sd7_ff.pneg) ? -$signed(magc) : $signed(magc);

      // stage 9: motor values
      v9_in[0] = 10'(ad8_ff);
      if (str8_ff) begin
         v9_in[1] = 10'(bc8_ff);
         v9_in[2] = apply_corr(bc8_ff, pos8_ff, g8_ff, nz8_ff);
         v9_in[3] = apply_corr(ad8_ff, pos8_ff, g8_ff, nz8_ff);
      end else begin
         v9_in[1] = apply_corr(bc8_ff, pos8_ff, g8_ff, nz8_ff);
         v9_in[2] = 10'(bc8_ff);
         v9_in[3] = apply_corr(ad8_ff, !pos8_ff, g8_ff, nz8_ff);
      end

      // stage 10 and 11: full scale product, percent divide, pin code
      for (int i = 0; i < MOTORS; i++) begin
         n10_in[i] = v9_ff[i] < 0;
         vmag[i]   = n10_in[i] ? VM_W'(-v9_ff[i]) : VM_W'(v9_ff[i]);
         p10_in[i] = PW_W'(vmag[i]) * PW_W'(maxp_ff[i]);
         ppct[i]   = PP_W'(p10_ff[i]) * PP_W'(PCT_RECIP);
         mg[i]     = ppct[i][PCT_SHIFT +: MG_W];
         duty11_in[i] = (mg[i] > MG_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : DUTY_W'(mg[i]);
         if (mg[i] == '0) begin
            br11_in[i] = BRIDGE_OFF;
         end else if (n10_ff[i] ^ inv_ff[i]) begin
            br11_in[i] = BRIDGE_PIN1;
         end else begin
            br11_in[i] = BRIDGE_PIN2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ue1_ff  <= ue1_in;
         uw1_ff  <= uw1_in;
         sd1_ff  <= sd1_in;
         qe2_ff  <= qe2_in;
         qw2_ff  <= qw2_in;
         ue2_ff  <= ue1_ff;
         uw2_ff  <= uw1_ff;
         sd2_ff  <= sd1_ff;
         e3_ff   <= e3_in;
         w3_ff   <= w3_in;
         sd3_ff  <= sd2_ff;
         t4_ff   <= t4_in;
         k4_ff   <= k4_in;
         pos4_ff <= pos4_in;
         sd4_ff  <= sd3_ff;
         fs5_ff  <= fs5_in;
         fc5_ff  <= fc5_in;
         is5_ff  <= is5_in;
         ic5_ff  <= ic5_in;
         g5_ff   <= g5_in;
         k5_ff   <= k4_ff;
         pos5_ff <= pos4_ff;
         sd5_ff  <= sd4_ff;
         bs6_ff  <= bs6_in;
         bc6_ff  <= bc6_in;
         ps6_ff  <= ps6_in;
         pc6_ff  <= pc6_in;
         ns6_ff  <= fs5_ff.neg;
         nc6_ff  <= fc5_ff.neg;
         g6_ff   <= g5_ff;
         nz6_ff  <= nz6_in;
         pos6_ff <= pos5_ff;
         sd6_ff  <= sd5_ff;
         vs7_ff  <= vs7_in;
         vc7_ff  <= vc7_in;
         ns7_ff  <= ns6_ff;
         nc7_ff  <= nc6_ff;
         g7_ff   <= g6_ff;
         nz7_ff  <= nz6_ff;
         pos7_ff <= pos6_ff;
         sd7_ff  <= sd6_ff;
         ad8_ff  <= ad8_in;
         bc8_ff  <= bc8_in;
         g8_ff   <= g7_ff;
         nz8_ff  <= nz7_ff;
         pos8_ff <= pos7_ff;
         str8_ff <= sd7_ff.straight;
         for (int i = 0; i < MOTORS; i++) begin
            v9_ff[i]     <= v9_in[i];
            p10_ff[i]    <= p10_in[i];
            n10_ff[i]    <= n10_in[i];
            duty11_ff[i] <= duty11_in[i];
            br11_ff[i]   <= br11_in[i];
         end
      end
   end

   assign rsp_duty_a   = duty11_ff[0];
   assign rsp_duty_b   = duty11_ff[1];
   assign rsp_duty_c   = duty11_ff[2];
   assign rsp_duty_d   = duty11_ff[3];
   assign rsp_bridge_a = br11_ff[0];
   assign rsp_bridge_b = br11_ff[1];
   assign rsp_bridge_c = br11_ff[2];
   assign rsp_bridge_d = br11_ff[3];

endmodule
